### sv/gws_pkg.sv
package gws_pkg;

    localparam int MAX_DIM   = 16;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 3 * DIM_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int SIZE_W    = 5;
    localparam int GAIN_W    = 24;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = DATA_W + 3;
    localparam int DIV_W     = DATA_W + 2;
    localparam int QUO_W     = DATA_W + 1;
    localparam int DIFF_W    = DATA_W + 2;
    localparam int PROD_W    = DIFF_W + GAIN_W + 1;
    localparam int FORCE_W   = PROD_W - GAIN_W;
    localparam int STAT_W    = 2;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;

    // divide by six as a halving and a reciprocal multiply by ceil(2^35 / 3),
    // exact for every dividend below 2^33, split into two partial products
    localparam int HALF_W    = DIV_W - 1;
    localparam int LO_W      = 17;
    localparam int HI_W      = HALF_W - LO_W;
    localparam int RECIP_W   = 34;
    localparam int RECIP_SH  = 35;
    localparam int PPROD_W   = HALF_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 = 34'd11453246123;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd3;

    // command from the sequencer or the top level to every lane
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              load_we;
        logic              cap_valid;
        logic              cap_center;
        logic              div_init;
        logic              div_step;
        logic              diff_en;
        logic              mul_en;
        logic              vel_en;
        logic              upd_we;
        logic              copy_we;
    } lane_cmd_t;

    // clamp a configured size to the grid
    function automatic logic [SIZE_W-1:0] dim_in_use(input logic [SIZE_W-1:0] s);
        return (s > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : s;
    endfunction

endpackage

### sv/grid_wave_stencil_step_top.sv
// Grid wave stencil engine: keeps up to 16x16x16 nodes of position and velocity
// (signed Q16.16, three components) and answers one result for every request.
// Requests are taken one at a time: a load passes from its transfer through the
// execute and response states to the output register, a read also through a
// read-wait state, and the next request is accepted in the cycle the result
// appears; a result not yet taken holds the next one in its last stage. A step
// walks every interior node in turn: the update pass makes seven single-port
// position reads, a reciprocal multiply for the divide by six of the neighbor
// sum, then difference, multiply, velocity and position stages for each node,
// and the copy pass reads each next position and writes it back. The three
// components run in three parallel lanes, each with its own stores, and their
// saturation flags are merged into the status.
// Nodes must be loaded before they are read or stepped over.
module grid_wave_stencil_step_top
    import gws_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // node_x, node_y, node_z, load_pos_x/y/z, load_vel_x/y/z, zero pad
    input  logic [207:0]         s_tdata,
    // req_type
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_pos_x/y/z, out_vel_x/y/z, iteration_count
    output logic [223:0]         m_tdata,
    // status
    output logic [STAT_W-1:0]    m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0] {T_IDLE, T_EXEC, T_RDWAIT, T_STEP, T_RESP} top_state_t;

    top_state_t               state_reg;
    logic [REQ_W-1:0]         req_reg;
    logic [DIM_W-1:0]         nx_reg, ny_reg, nz_reg;
    logic signed [DATA_W-1:0] ld_pos_reg [3];
    logic signed [DATA_W-1:0] ld_vel_reg [3];
    logic signed [DATA_W-1:0] res_pos_reg [3];
    logic signed [DATA_W-1:0] res_vel_reg [3];
    logic [STAT_W-1:0]        res_stat_reg;
    logic [DATA_W-1:0]        step_cnt_reg;
    logic                     sat_reg;
    logic                     m_valid_reg;
    logic [223:0]             m_data_reg;
    logic [STAT_W-1:0]        m_user_reg;
    logic [SIZE_W-1:0]        size_x_reg, size_y_reg, size_z_reg;
    logic [GAIN_W-1:0]        gain_reg;

    lane_cmd_t                seq_cmd, top_cmd, lane_cmd;
    logic                     seq_busy, seq_done, seq_start;
    logic signed [DATA_W-1:0] rd_pos [3];
    logic signed [DATA_W-1:0] rd_vel [3];
    logic [2:0]               sat_hits;
    logic                     node_ok;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_W'(11);
            size_y_reg <= SIZE_W'(11);
            size_z_reg <= SIZE_W'(11);
            gain_reg   <= GAIN_W'(13981);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SIZE_X: size_x_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_SIZE_Y: size_y_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_SIZE_Z: size_z_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_GAIN:   gain_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign node_ok = ({1'b0, nx_reg} < dim_in_use(size_x_reg))
                  && ({1'b0, ny_reg} < dim_in_use(size_y_reg))
                  && ({1'b0, nz_reg} < dim_in_use(size_z_reg));

    // single-node access command
    always_comb begin
        top_cmd         = '0;
        top_cmd.addr    = {nx_reg, ny_reg, nz_reg};
        top_cmd.load_we = (state_reg == T_EXEC) && (req_reg == REQ_LOAD) && node_ok;
        lane_cmd        = seq_busy ? seq_cmd : top_cmd;
    end

    assign seq_start = (state_reg == T_EXEC) && (req_reg == REQ_STEP);

    gws_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (seq_start),
        .size_x  (size_x_reg),
        .size_y  (size_y_reg),
        .size_z  (size_z_reg),
        .cmd     (seq_cmd),
        .busy    (seq_busy),
        .done    (seq_done)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        gws_lane u_lane (
            .aclk     (aclk),
            .cmd      (lane_cmd),
            .gain     (gain_reg),
            .load_pos (ld_pos_reg[g]),
            .load_vel (ld_vel_reg[g]),
            .rd_pos   (rd_pos[g]),
            .rd_vel   (rd_vel[g]),
            .sat_hit  (sat_hits[g])
        );
    end

    // request control, result merge and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            m_valid_reg  <= 1'b0;
            step_cnt_reg <= '0;
            sat_reg      <= 1'b0;
        end else begin
            if (m_tready && (state_reg != T_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (s_tvalid) begin
                        req_reg <= s_tuser;
                        nx_reg  <= s_tdata[3:0];
                        ny_reg  <= s_tdata[7:4];
                        nz_reg  <= s_tdata[11:8];
                        for (int c = 0; c < 3; c++) begin
                            ld_pos_reg[c] <= s_tdata[12 + 32*c +: 32];
                            ld_vel_reg[c] <= s_tdata[108 + 32*c +: 32];
                        end
                        state_reg <= T_EXEC;
                    end
                end
                T_EXEC: begin
                    for (int c = 0; c < 3; c++) begin
                        res_pos_reg[c] <= '0;
                        res_vel_reg[c] <= '0;
                    end
                    sat_reg <= 1'b0;
                    case (req_reg)
                        REQ_LOAD: begin
                            res_stat_reg <= node_ok ? STAT_OK : STAT_RANGE;
                            state_reg    <= T_RESP;
                        end
                        REQ_READ: begin
                            res_stat_reg <= node_ok ? STAT_OK : STAT_RANGE;
                            state_reg    <= node_ok ? T_RDWAIT : T_RESP;
                        end
                        REQ_STEP: begin
                            res_stat_reg <= STAT_OK;
                            state_reg    <= T_STEP;
                        end
                        default: begin
                            res_stat_reg <= STAT_OK;
                            state_reg    <= T_RESP;
                        end
                    endcase
                end
                T_RDWAIT: begin
                    for (int c = 0; c < 3; c++) begin
                        res_pos_reg[c] <= rd_pos[c];
                        res_vel_reg[c] <= rd_vel[c];
                    end
                    state_reg <= T_RESP;
                end
                T_STEP: begin
                    sat_reg <= sat_reg || (|sat_hits);
                    if (seq_done) begin
                        step_cnt_reg <= step_cnt_reg + 1'b1;
                        res_stat_reg <= (sat_reg || (|sat_hits)) ? STAT_SAT : STAT_OK;
                        state_reg    <= T_RESP;
                    end
                end
                T_RESP: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {step_cnt_reg,
                                        res_vel_reg[2], res_vel_reg[1], res_vel_reg[0],
                                        res_pos_reg[2], res_pos_reg[1], res_pos_reg[0]};
                        m_user_reg  <= res_stat_reg;
                        state_reg   <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == T_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

### sv/gws_lane.sv
module gws_lane
    import gws_pkg::*;
(
    input  logic                     aclk,
    input  lane_cmd_t                cmd,
    input  logic        [GAIN_W-1:0] gain,
    input  logic signed [DATA_W-1:0] load_pos,
    input  logic signed [DATA_W-1:0] load_vel,
    output logic signed [DATA_W-1:0] rd_pos,
    output logic signed [DATA_W-1:0] rd_vel,
    output logic                     sat_hit
);

    logic signed [DATA_W-1:0] pos_mem [DEPTH];
    logic signed [DATA_W-1:0] vel_mem [DEPTH];
    logic signed [DATA_W-1:0] nxt_mem [DEPTH];

    logic signed [DATA_W-1:0] pos_rd_reg, vel_rd_reg, nxt_rd_reg;
    logic signed [DATA_W-1:0] center_reg, velc_reg, nv_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     neg_reg;
    logic [LO_W+RECIP_W-1:0]  pp_lo_reg;
    logic [HI_W+RECIP_W-1:0]  pp_hi_reg;
    logic        [QUO_W-1:0]  quo_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [SUM_W-1:0]   mag;
    logic        [HALF_W-1:0]  half_mag;
    logic        [PPROD_W-1:0] pprod;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [FORCE_W-1:0] force_val;
    logic signed [FORCE_W:0]   nv_full;
    logic                      nv_sat;
    logic signed [DATA_W-1:0]  nv_next;
    logic signed [DATA_W:0]    np_full;
    logic                      np_sat;
    logic signed [DATA_W-1:0]  np_val;

    // position store: loaded or copied from the next-position store
    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            pos_mem[cmd.addr] <= load_pos;
        end else if (cmd.copy_we) begin
            pos_mem[cmd.addr] <= nxt_rd_reg;
        end
        pos_rd_reg <= pos_mem[cmd.addr];
    end

    // velocity store
    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            vel_mem[cmd.addr] <= load_vel;
        end else if (cmd.upd_we) begin
            vel_mem[cmd.addr] <= nv_reg;
        end
        vel_rd_reg <= vel_mem[cmd.addr];
    end

    // next-position store
    always_ff @(posedge aclk) begin
        if (cmd.upd_we) begin
            nxt_mem[cmd.addr] <= np_val;
        end
        nxt_rd_reg <= nxt_mem[cmd.addr];
    end

    // datapath helpers
    always_comb begin
        mag       = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
        half_mag  = mag[DIV_W-1:1];
        pprod     = {pp_hi_reg, LO_W'(0)} + PPROD_W'(pp_lo_reg);
        diff_next = neg_reg
                  ? DIFF_W'(center_reg) + $signed({1'b0, quo_reg})
                  : DIFF_W'(center_reg) - $signed({1'b0, quo_reg});
        force_val = prod_reg[PROD_W-1:GAIN_W];
        nv_full   = (FORCE_W+1)'(velc_reg) - (FORCE_W+1)'(force_val);
        nv_sat    = !((&nv_full[FORCE_W:DATA_W-1]) || !(|nv_full[FORCE_W:DATA_W-1]));
        nv_next   = nv_sat ? (nv_full[FORCE_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                : {1'b0, {(DATA_W-1){1'b1}}})
                           : nv_full[DATA_W-1:0];
        np_full   = (DATA_W+1)'(center_reg) + (DATA_W+1)'(nv_reg);
        np_sat    = np_full[DATA_W] != np_full[DATA_W-1];
        np_val    = np_sat ? (np_full[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                              : {1'b0, {(DATA_W-1){1'b1}}})
                           : np_full[DATA_W-1:0];
    end

    // stencil arithmetic, one stage per command
    always_ff @(posedge aclk) begin
        if (cmd.cap_valid) begin
            if (cmd.cap_center) begin
                center_reg <= pos_rd_reg;
                velc_reg   <= vel_rd_reg;
                sum_reg    <= '0;
            end else begin
                sum_reg <= sum_reg + SUM_W'(pos_rd_reg);
            end
        end
        // magnitude of the sum over six: halve, then two partial products by 1/3
        if (cmd.div_init) begin
            neg_reg   <= sum_reg[SUM_W-1];
            pp_lo_reg <= half_mag[LO_W-1:0] * RECIP3;
            pp_hi_reg <= half_mag[HALF_W-1:LO_W] * RECIP3;
        end
        if (cmd.div_step) begin
            quo_reg <= QUO_W'(pprod[PPROD_W-1:RECIP_SH]);
        end
        if (cmd.diff_en) begin
            diff_reg <= diff_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= diff_reg * $signed({1'b0, gain});
        end
        if (cmd.vel_en) begin
            nv_reg <= nv_next;
        end
    end

    assign rd_pos  = pos_rd_reg;
    assign rd_vel  = vel_rd_reg;
    assign sat_hit = (cmd.vel_en && nv_sat) || (cmd.upd_we && np_sat);

endmodule

### sv/gws_seq.sv
module gws_seq
    import gws_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SIZE_W-1:0] size_x,
    input  logic [SIZE_W-1:0] size_y,
    input  logic [SIZE_W-1:0] size_z,
    output lane_cmd_t         cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [3:0] {
        S_IDLE, S_TAP, S_LAST, S_DINIT, S_DIV, S_DIFF, S_MUL, S_VEL, S_UPD,
        S_CRD, S_CWR, S_DONE
    } seq_state_t;

    seq_state_t        state_reg;
    logic [DIM_W-1:0]  ix_reg, iy_reg, iz_reg;
    logic [2:0]        tap_reg;
    logic              cap_v_reg, cap_c_reg;

    logic [SIZE_W-1:0] dx, dy, dz;
    logic [DIM_W-1:0]  lx, ly, lz;
    logic              has_interior, last_node;
    logic [ADDR_W-1:0] center;

    always_comb begin
        dx = dim_in_use(size_x);
        dy = dim_in_use(size_y);
        dz = dim_in_use(size_z);
        lx = DIM_W'(dx - SIZE_W'(2));
        ly = DIM_W'(dy - SIZE_W'(2));
        lz = DIM_W'(dz - SIZE_W'(2));
        has_interior = (dx >= SIZE_W'(3)) && (dy >= SIZE_W'(3)) && (dz >= SIZE_W'(3));
        last_node = (ix_reg == lx) && (iy_reg == ly) && (iz_reg == lz);
        center = {ix_reg, iy_reg, iz_reg};
    end

    // address and strobes for the lanes
    always_comb begin
        cmd            = '0;
        cmd.addr       = center;
        cmd.cap_valid  = cap_v_reg;
        cmd.cap_center = cap_c_reg;
        case (state_reg)
            S_TAP: begin
                case (tap_reg)
                    3'd1:    cmd.addr = {ix_reg - 1'b1, iy_reg, iz_reg};
                    3'd2:    cmd.addr = {ix_reg + 1'b1, iy_reg, iz_reg};
                    3'd3:    cmd.addr = {ix_reg, iy_reg - 1'b1, iz_reg};
                    3'd4:    cmd.addr = {ix_reg, iy_reg + 1'b1, iz_reg};
                    3'd5:    cmd.addr = {ix_reg, iy_reg, iz_reg - 1'b1};
                    3'd6:    cmd.addr = {ix_reg, iy_reg, iz_reg + 1'b1};
                    default: cmd.addr = center;
                endcase
            end
            S_DINIT: cmd.div_init = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_DIFF:  cmd.diff_en  = 1'b1;
            S_MUL:   cmd.mul_en   = 1'b1;
            S_VEL:   cmd.vel_en   = 1'b1;
            S_UPD:   cmd.upd_we   = 1'b1;
            S_CWR:   cmd.copy_we  = 1'b1;
            default: ;
        endcase
    end

    // walk interior nodes: update pass, then copy pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cap_v_reg <= 1'b0;
            cap_c_reg <= 1'b0;
            done      <= 1'b0;
        end else begin
            cap_v_reg <= (state_reg == S_TAP);
            cap_c_reg <= (state_reg == S_TAP) && (tap_reg == 3'd0);
            done      <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        ix_reg  <= DIM_W'(1);
                        iy_reg  <= DIM_W'(1);
                        iz_reg  <= DIM_W'(1);
                        tap_reg <= '0;
                        state_reg <= has_interior ? S_TAP : S_DONE;
                    end
                end
                S_TAP: begin
                    tap_reg <= tap_reg + 3'd1;
                    if (tap_reg == 3'd6) begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:  state_reg <= S_DINIT;
                S_DINIT: state_reg <= S_DIV;
                S_DIV:   state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_MUL;
                S_MUL:   state_reg <= S_VEL;
                S_VEL:   state_reg <= S_UPD;
                S_UPD, S_CWR: begin
                    tap_reg <= '0;
                    if (last_node) begin
                        ix_reg <= DIM_W'(1);
                        iy_reg <= DIM_W'(1);
                        iz_reg <= DIM_W'(1);
                        state_reg <= (state_reg == S_UPD) ? S_CRD : S_DONE;
                    end else begin
                        if (iz_reg == lz) begin
                            iz_reg <= DIM_W'(1);
                            if (iy_reg == ly) begin
                                iy_reg <= DIM_W'(1);
                                ix_reg <= ix_reg + 1'b1;
                            end else begin
                                iy_reg <= iy_reg + 1'b1;
                            end
                        end else begin
                            iz_reg <= iz_reg + 1'b1;
                        end
                        state_reg <= (state_reg == S_UPD) ? S_TAP : S_CRD;
                    end
                end
                S_CRD: state_reg <= S_CWR;
                S_DONE: begin
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### tb/tb_grid_wave_stencil_step_top.sv
module tb_grid_wave_stencil_step_top;
    import gws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    // idling modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [3:0]        x, y, z;
        logic [DATA_W-1:0] pos [3];
        logic [DATA_W-1:0] vel [3];
    } node_req_t;

    typedef struct {
        logic [DATA_W-1:0] pos [3];
        logic [DATA_W-1:0] vel [3];
        logic [DATA_W-1:0] iter;
        logic [STAT_W-1:0] status;
    } node_resp_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [207:0]         s_tdata = '0;
    logic [REQ_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [223:0]         m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [GAIN_W-1:0]    cfg_wdata = '0;

    grid_wave_stencil_step_top u_top (.*);

    // grid image, configuration and counters
    int          pos_mem [3][DEPTH];
    int          vel_mem [3][DEPTH];
    int          nxt_mem [3][DEPTH];
    logic [31:0] step_cnt = '0;
    logic [4:0]  sz_x = 5'd11, sz_y = 5'd11, sz_z = 5'd11;
    logic [23:0] gain = 24'd13981;

    node_req_t  pending_q [$];
    node_resp_t expected_q [$];
    node_req_t  cur_req;
    int         idle_mode = IDLE_NONE;
    int         errors = 0;
    int         cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int node_idx(int x, int y, int z);
        return (x * MAX_DIM + y) * MAX_DIM + z;
    endfunction

    function automatic int clamp_dim(logic [4:0] s);
        return (s > MAX_DIM) ? MAX_DIM : int'(s);
    endfunction

    function automatic int sat32(longint v, ref bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h80000000;
        end
        return int'(v);
    endfunction

    // Jacobi update over interior nodes; returns the saturation flag
    function automatic bit grid_update();
        int  sx, sy, sz, n;
        longint sum, avg, diff, force_v;
        int  nv;
        bit  sat;
        sx = clamp_dim(sz_x);
        sy = clamp_dim(sz_y);
        sz = clamp_dim(sz_z);
        sat = 1'b0;
        for (int i = 1; i + 1 < sx; i++)
            for (int j = 1; j + 1 < sy; j++)
                for (int k = 1; k + 1 < sz; k++) begin
                    n = node_idx(i, j, k);
                    for (int c = 0; c < 3; c++) begin
                        sum = longint'(pos_mem[c][n-256]) + longint'(pos_mem[c][n+256])
                            + longint'(pos_mem[c][n-16]) + longint'(pos_mem[c][n+16])
                            + longint'(pos_mem[c][n-1]) + longint'(pos_mem[c][n+1]);
                        avg = sum / 6;
                        diff = longint'(pos_mem[c][n]) - avg;
                        force_v = (diff * longint'({40'd0, gain})) >>> 24;
                        nv = sat32(longint'(vel_mem[c][n]) - force_v, sat);
                        vel_mem[c][n] = nv;
                        nxt_mem[c][n] = sat32(longint'(pos_mem[c][n]) + longint'(nv), sat);
                    end
                end
        for (int i = 1; i + 1 < sx; i++)
            for (int j = 1; j + 1 < sy; j++)
                for (int k = 1; k + 1 < sz; k++)
                    for (int c = 0; c < 3; c++)
                        pos_mem[c][node_idx(i, j, k)] = nxt_mem[c][node_idx(i, j, k)];
        step_cnt = step_cnt + 1;
        return sat;
    endfunction

    // work out the response of one accepted request
    function automatic void predict_response(node_req_t r);
        node_resp_t e;
        bit in_range;
        int n;
        for (int c = 0; c < 3; c++) begin
            e.pos[c] = '0;
            e.vel[c] = '0;
        end
        e.status = STAT_OK;
        in_range = (r.x < clamp_dim(sz_x)) && (r.y < clamp_dim(sz_y))
                && (r.z < clamp_dim(sz_z));
        n = node_idx(r.x, r.y, r.z);
        if (r.kind == REQ_LOAD || r.kind == REQ_READ) begin
            if (!in_range) begin
                e.status = STAT_RANGE;
            end else if (r.kind == REQ_LOAD) begin
                for (int c = 0; c < 3; c++) begin
                    pos_mem[c][n] = r.pos[c];
                    vel_mem[c][n] = r.vel[c];
                end
            end else begin
                for (int c = 0; c < 3; c++) begin
                    e.pos[c] = pos_mem[c][n];
                    e.vel[c] = vel_mem[c][n];
                end
            end
        end else if (r.kind == REQ_STEP) begin
            if (grid_update()) e.status = STAT_SAT;
        end
        e.iter = step_cnt;
        expected_q.push_back(e);
    endfunction

    function automatic bit idle_now(bit sender);
        int pct;
        pct = 0;
        if (idle_mode == IDLE_BOTH) pct = 10;
        else if (sender && idle_mode == IDLE_SEND) pct = 46;
        else if (!sender && idle_mode == IDLE_RECV) pct = 46;
        return $urandom_range(99) < pct;
    endfunction

    // driver: present queued requests, predict on each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_response(cur_req);
            if (pending_q.size() > 0 && !idle_now(1'b1)) begin
                cur_req = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_req.kind;
                s_tdata <= {4'd0, cur_req.vel[2], cur_req.vel[1], cur_req.vel[0],
                            cur_req.pos[2], cur_req.pos[1], cur_req.pos[0],
                            cur_req.z, cur_req.y, cur_req.x};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        node_resp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    for (int c = 0; c < 3; c++) begin
                        if (m_tdata[32*c +: 32] !== e.pos[c]) begin
                            $error("out_pos[%0d] expected %h got %h", c, e.pos[c],
                                   m_tdata[32*c +: 32]);
                            errors++;
                        end
                        if (m_tdata[96+32*c +: 32] !== e.vel[c]) begin
                            $error("out_vel[%0d] expected %h got %h", c, e.vel[c],
                                   m_tdata[96+32*c +: 32]);
                            errors++;
                        end
                    end
                    if (m_tdata[223:192] !== e.iter) begin
                        $error("iteration_count expected %0d got %0d", e.iter, m_tdata[223:192]);
                        errors++;
                    end
                    if (m_tuser !== e.status) begin
                        $error("status expected %0d got %0d", e.status, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= !idle_now(1'b0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            3: return 32'h0;
            default: return 32'($urandom_range(2097152)) - 32'd1048576;
        endcase
    endfunction

    function automatic void queue_req(logic [REQ_W-1:0] kind, int x, int y, int z);
        node_req_t r;
        r.kind = kind;
        r.x = 4'(x);
        r.y = 4'(y);
        r.z = 4'(z);
        for (int c = 0; c < 3; c++) begin
            r.pos[c] = (kind == REQ_LOAD) ? rand_word() : $urandom;
            r.vel[c] = (kind == REQ_LOAD) ? rand_word() : $urandom;
        end
        pending_q.push_back(r);
    endfunction

    // hold until the block has drained
    task automatic wait_drained();
        while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SIZE_X: sz_x = val[4:0];
            CFG_SIZE_Y: sz_y = val[4:0];
            CFG_SIZE_Z: sz_z = val[4:0];
            CFG_GAIN:   gain = val;
            default: ;
        endcase
    endtask

    task automatic setup(int sx, int sy, int sz, int g, bit fill);
        wait_drained();
        cfg_write(CFG_SIZE_X, GAIN_W'(sx));
        cfg_write(CFG_SIZE_Y, GAIN_W'(sy));
        cfg_write(CFG_SIZE_Z, GAIN_W'(sz));
        cfg_write(CFG_GAIN, GAIN_W'(g));
        // load every node in use so steps and reads see written entries
        if (fill) begin
            for (int i = 0; i < clamp_dim(sz_x); i++)
                for (int j = 0; j < clamp_dim(sz_y); j++)
                    for (int k = 0; k < clamp_dim(sz_z); k++)
                        queue_req(REQ_LOAD, i, j, k);
        end
    endtask

    task automatic random_ops(int mode, int count);
        int x, y, z, pick;
        idle_mode = mode;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if ($urandom_range(4) == 0) begin
                x = $urandom_range(15);
                y = $urandom_range(15);
                z = $urandom_range(15);
            end else begin
                x = $urandom_range(clamp_dim(sz_x) > 0 ? clamp_dim(sz_x) - 1 : 0);
                y = $urandom_range(clamp_dim(sz_y) > 0 ? clamp_dim(sz_y) - 1 : 0);
                z = $urandom_range(clamp_dim(sz_z) > 0 ? clamp_dim(sz_z) - 1 : 0);
            end
            if (pick < 45) queue_req(REQ_READ, x, y, z);
            else if (pick < 75) queue_req(REQ_LOAD, x, y, z);
            else if (pick < 92) queue_req(REQ_STEP, x, y, z);
            else queue_req(REQ_NONE, x, y, z);
        end
        wait_drained();
    endtask

    initial begin
        node_req_t r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: smallest grid with an interior node, full gain, extreme contents
        setup(3, 3, 3, 24'hffffff, 1'b0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++) begin
                    r.kind = REQ_LOAD;
                    r.x = 4'(i);
                    r.y = 4'(j);
                    r.z = 4'(k);
                    for (int c = 0; c < 3; c++) begin
                        r.pos[c] = ((i + j + k + c) % 2) ? 32'h7fffffff : 32'h80000000;
                        r.vel[c] = (c == 0) ? 32'h80000000 : 32'h7fffffff;
                    end
                    if (i == 1 && j == 1 && k == 1) begin
                        r.pos[0] = 32'h80000000;
                        r.vel[0] = 32'h80000000;
                    end
                    pending_q.push_back(r);
                end
        queue_req(REQ_READ, 0, 0, 0);
        queue_req(REQ_STEP, 0, 0, 0);
        queue_req(REQ_READ, 1, 1, 1);
        queue_req(REQ_LOAD, 15, 15, 15);
        queue_req(REQ_READ, 15, 15, 15);
        queue_req(REQ_READ, 3, 0, 0);
        queue_req(REQ_NONE, 15, 15, 15);
        queue_req(REQ_STEP, 0, 0, 0);
        queue_req(REQ_READ, 2, 2, 2);
        queue_req(REQ_READ, 1, 1, 1);

        // random phases over several settings
        setup(3, 4, 3, 13981, 1'b1);
        random_ops(IDLE_NONE, 20);
        random_ops(IDLE_SEND, 20);
        setup(3, 3, 3, 24'hffffff, 1'b1);
        random_ops(IDLE_RECV, 20);
        random_ops(IDLE_BOTH, 20);
        setup(2, 7, 0, 0, 1'b1);
        random_ops(IDLE_BOTH, 10);
        // sizes above the maximum clamp to it
        setup(17, 3, 1, 24'h123456, 1'b1);
        idle_mode = IDLE_NONE;
        queue_req(REQ_STEP, 0, 0, 0);
        queue_req(REQ_READ, 15, 2, 0);
        queue_req(REQ_READ, 15, 3, 0);
        queue_req(REQ_READ, 8, 1, 0);
        random_ops(IDLE_NONE, 6);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
sv/gws_pkg.sv
sv/gws_lane.sv
sv/gws_seq.sv
sv/grid_wave_stencil_step_top.sv
tb/tb_grid_wave_stencil_step_top.sv
